[sv/scdt_pkg.sv]
package scdt_pkg;

    localparam int unsigned Sessions  = 16;
    localparam int unsigned IdxBits   = (Sessions > 1) ? $clog2(Sessions) : 1;
    localparam int unsigned CntBits   = $clog2(Sessions + 1);
    localparam int unsigned CountBits = 48;
    localparam int unsigned KeyBits   = 32;
    localparam int unsigned TimeBits  = 48;
    localparam int unsigned StatBits  = 3;
    localparam int unsigned RemBits   = 5;
    localparam logic [TimeBits-1:0] IdleReset = TimeBits'(60000);

    typedef enum logic [StatBits-1:0] {
        ST_DELTA    = 3'd0,
        ST_NEW      = 3'd1,
        ST_SHRINK   = 3'd2,
        ST_FULL     = 3'd3,
        ST_SWEEP    = 3'd4
    } t_status;

    typedef struct packed {
        logic load;
        logic sweep;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic    is_sweep;
        t_status status;
    } t_stat;

endpackage

[sv/scdt_if.sv]
interface scdt_in_if;
    logic                              valid;
    logic                              ready;
    logic                              op;
    logic [scdt_pkg::KeyBits-1:0]      session_id;
    logic [scdt_pkg::CountBits-1:0]    in_tokens;
    logic [scdt_pkg::CountBits-1:0]    out_tokens;
    logic [scdt_pkg::CountBits-1:0]    cache_make_tokens;
    logic [scdt_pkg::CountBits-1:0]    cache_hit_tokens;
    logic [scdt_pkg::TimeBits-1:0]     now_ms;
    modport source (output valid, op, session_id, in_tokens, out_tokens,
                    cache_make_tokens, cache_hit_tokens, now_ms, input ready);
    modport sink (input valid, op, session_id, in_tokens, out_tokens,
                  cache_make_tokens, cache_hit_tokens, now_ms, output ready);
endinterface

interface scdt_out_if;
    logic                              valid;
    logic                              ready;
    logic [scdt_pkg::StatBits-1:0]     status;
    logic [47:0]                       delta_in;
    logic [47:0]                       delta_out;
    logic [47:0]                       delta_cache_make;
    logic [47:0]                       delta_cache_hit;
    logic [47:0]                       elapsed_ms;
    logic [scdt_pkg::RemBits-1:0]      removed_count;
    modport source (output valid, status, delta_in, delta_out, delta_cache_make,
                    delta_cache_hit, elapsed_ms, removed_count, input ready);
    modport sink (input valid, status, delta_in, delta_out, delta_cache_make,
                  delta_cache_hit, elapsed_ms, removed_count, output ready);
endinterface

interface scdt_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [scdt_pkg::TimeBits-1:0]     data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

[sv/session_counter_delta_table.sv]
// channel | dir | handshake   | payload
// in_ch   | in  | valid/ready | op, session_id, four counters, now_ms
// out_ch  | out | valid/ready | status, four deltas, elapsed_ms, removed_count
// cfg_ch  | in  | valid/ready | data = idle_limit_ms
// Each transaction passes through accept with key match, commit and output, in that order.
// Rate is set by the single controller sequence over one entry table.
// Reset clears valid and flag marks and sets the idle limit to 60000.
// A stalled output holds the block; the next item waits for it.
module session_counter_delta_table (
    input  logic      i_clk,
    input  logic      i_rst_n,
    scdt_in_if.sink   in_ch,
    scdt_out_if.source out_ch,
    scdt_cfg_if.sink  cfg_ch
);
    scdt_pkg::t_cmd  cmd;
    scdt_pkg::t_stat stat;

    scdt_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .o_in_ready(in_ch.ready),
        .o_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
        .i_stat(stat), .o_cmd(cmd)
    );

    scdt_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(cmd), .o_stat(stat),
        .in_ch(in_ch), .cfg_ch(cfg_ch),
        .o_status(out_ch.status),
        .o_delta_in(out_ch.delta_in),
        .o_delta_out(out_ch.delta_out),
        .o_delta_cache_make(out_ch.delta_cache_make),
        .o_delta_cache_hit(out_ch.delta_cache_hit),
        .o_elapsed_ms(out_ch.elapsed_ms),
        .o_removed_count(out_ch.removed_count)
    );
endmodule

[sv/scdt_datapath.sv]
module scdt_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  scdt_pkg::t_cmd                  i_cmd,
    output scdt_pkg::t_stat                 o_stat,
    scdt_in_if.sink                         in_ch,
    scdt_cfg_if.sink                        cfg_ch,
    output logic [scdt_pkg::StatBits-1:0]   o_status,
    output logic [47:0]                     o_delta_in,
    output logic [47:0]                     o_delta_out,
    output logic [47:0]                     o_delta_cache_make,
    output logic [47:0]                     o_delta_cache_hit,
    output logic [47:0]                     o_elapsed_ms,
    output logic [scdt_pkg::RemBits-1:0]    o_removed_count
);
    localparam int unsigned N  = scdt_pkg::Sessions;
    localparam int unsigned CB = scdt_pkg::CountBits;
    localparam int unsigned TB = scdt_pkg::TimeBits;

    logic [TB-1:0]                   r_idle;
    logic [N-1:0]                    r_valid;
    logic [N-1:0]                    r_flag;
    logic [scdt_pkg::KeyBits-1:0]    r_key  [N];
    logic [CB-1:0]                   r_base [N][4];
    logic [TB-1:0]                   r_seen [N];

    logic                            r_op;
    logic [scdt_pkg::KeyBits-1:0]    r_id;
    logic [CB-1:0]                   r_c [4];
    logic [TB-1:0]                   r_now;
    logic [N-1:0]                    r_match;
    logic [N-1:0]                    r_expire;

    logic [N-1:0]                    n_match;
    logic [N-1:0]                    n_expire;
    logic                            hit, spare_ok, shrink;
    logic [scdt_pkg::IdxBits-1:0]    hit_idx, spare_idx;
    logic [scdt_pkg::CntBits-1:0]    removed;
    logic [CB-1:0]                   diff [4];
    logic [TB-1:0]                   el;
    scdt_pkg::t_status               st;

    assign cfg_ch.ready = 1'b1;

    always_comb begin
        for (int i = 0; i < N; i++) begin
            n_match[i]  = r_valid[i] && (r_key[i] == in_ch.session_id);
            n_expire[i] = r_valid[i] && (in_ch.now_ms > r_seen[i])
                          && ((in_ch.now_ms - r_seen[i]) > r_idle);
        end
    end

    always_comb begin
        hit = 1'b0;
        hit_idx = '0;
        spare_ok = 1'b0;
        spare_idx = '0;
        removed = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                hit = 1'b1;
                hit_idx = scdt_pkg::IdxBits'(i);
            end
            if (!r_valid[i]) begin
                spare_ok = 1'b1;
                spare_idx = scdt_pkg::IdxBits'(i);
            end
        end
        for (int i = 0; i < N; i++) begin
            removed = removed + scdt_pkg::CntBits'(r_expire[i]);
        end
        shrink = 1'b0;
        for (int k = 0; k < 4; k++) begin
            diff[k] = r_c[k] - r_base[hit_idx][k];
            shrink  = shrink | (r_c[k] < r_base[hit_idx][k]);
        end
        el = (r_now > r_seen[hit_idx]) ? (r_now - r_seen[hit_idx]) : TB'(1);
        priority if (r_op) begin
            st = scdt_pkg::ST_SWEEP;
        end else if (!hit) begin
            st = spare_ok ? scdt_pkg::ST_NEW : scdt_pkg::ST_FULL;
        end else if (r_flag[hit_idx]) begin
            st = scdt_pkg::ST_NEW;
        end else if (shrink) begin
            st = scdt_pkg::ST_SHRINK;
        end else begin
            st = scdt_pkg::ST_DELTA;
        end
    end

    assign o_stat.is_sweep = r_op;
    assign o_stat.status   = st;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= in_ch.op;
            r_id     <= in_ch.session_id;
            r_c[0]   <= in_ch.in_tokens;
            r_c[1]   <= in_ch.out_tokens;
            r_c[2]   <= in_ch.cache_make_tokens;
            r_c[3]   <= in_ch.cache_hit_tokens;
            r_now    <= in_ch.now_ms;
            r_match  <= n_match;
            r_expire <= n_expire;
        end
        if (i_cmd.commit) begin
            o_status           <= st;
            o_delta_in         <= (st == scdt_pkg::ST_DELTA) ? 48'(diff[0]) : 48'd0;
            o_delta_out        <= (st == scdt_pkg::ST_DELTA) ? 48'(diff[1]) : 48'd0;
            o_delta_cache_make <= (st == scdt_pkg::ST_DELTA) ? 48'(diff[2]) : 48'd0;
            o_delta_cache_hit  <= (st == scdt_pkg::ST_DELTA) ? 48'(diff[3]) : 48'd0;
            o_elapsed_ms       <= (st == scdt_pkg::ST_DELTA) ? 48'(el) : 48'd0;
            o_removed_count    <= !r_op ? 5'd0 :
                                  (removed > 31) ? 5'd31 : scdt_pkg::RemBits'(removed);
            if (!r_op && (hit || spare_ok)) begin
                for (int k = 0; k < 4; k++) begin
                    r_base[hit ? hit_idx : spare_idx][k] <= r_c[k];
                end
                r_seen[hit ? hit_idx : spare_idx] <= r_now;
                if (!hit) begin
                    r_key[spare_idx] <= r_id;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle  <= scdt_pkg::IdleReset;
            r_valid <= '0;
            r_flag  <= '0;
        end else begin
            if (cfg_ch.valid) begin
                r_idle <= cfg_ch.data;
            end
            if (i_cmd.commit) begin
                if (r_op) begin
                    r_valid <= r_valid & ~r_expire;
                    r_flag  <= r_flag & ~r_expire;
                end else if (hit) begin
                    r_flag[hit_idx] <= (st == scdt_pkg::ST_SHRINK);
                end else if (spare_ok) begin
                    r_valid[spare_idx] <= 1'b1;
                    r_flag[spare_idx]  <= 1'b0;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_match_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> $onehot0(r_match)) else $error("duplicate key");
    a_flag_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_flag & ~r_valid) == '0) else $error("flag on free entry");
    a_sweep_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_op) |=> ((r_valid & r_expire) == '0))
        else $error("expired entry kept");
`endif
endmodule

[sv/scdt_ctrl.sv]
module scdt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  scdt_pkg::t_stat i_stat,
    output scdt_pkg::t_cmd  o_cmd
);
    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_OUT} t_state;
    t_state r_state;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_cmd.load   = o_in_ready && i_in_valid;
    assign o_cmd.sweep  = (r_state == S_EXEC) && i_stat.is_sweep;
    assign o_cmd.commit = (r_state == S_EXEC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_in_valid) r_state <= S_EXEC;
                S_EXEC: r_state <= S_OUT;
                S_OUT:  if (i_out_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_one_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> !o_cmd.commit) else $error("double commit");
    a_sweep_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.sweep |-> (i_stat.status == scdt_pkg::ST_SWEEP)) else $error("bad sweep");
    a_load_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.commit) else $error("load lost");
`endif
endmodule

[tb/tb_session_counter_delta_table.sv]
`timescale 1ns / 1ps

module tb_top;

    typedef struct packed {
        logic        op;
        logic [31:0] sid;
        logic [47:0] c0;
        logic [47:0] c1;
        logic [47:0] c2;
        logic [47:0] c3;
        logic [47:0] now;
    } t_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [47:0] d0;
        logic [47:0] d1;
        logic [47:0] d2;
        logic [47:0] d3;
        logic [47:0] el;
        logic [4:0]  rem;
    } t_res;

    logic i_clk;
    logic i_rst_n;

    scdt_in_if  in_ch ();
    scdt_out_if out_ch ();
    scdt_cfg_if cfg_ch ();

    session_counter_delta_table DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg_ch (cfg_ch.sink)
    );

    t_item pending_items[$];
    t_res  expected_results[$];
    int    errors;
    int    src_idle_pct;
    int    snk_stall_pct;
    logic  in_fire;

    logic [47:0] idle_limit;
    logic        tv[scdt_pkg::Sessions];
    logic        tflag[scdt_pkg::Sessions];
    logic [31:0] tkey[scdt_pkg::Sessions];
    logic [47:0] tb0[scdt_pkg::Sessions];
    logic [47:0] tb1[scdt_pkg::Sessions];
    logic [47:0] tb2[scdt_pkg::Sessions];
    logic [47:0] tb3[scdt_pkg::Sessions];
    logic [47:0] tseen[scdt_pkg::Sessions];

    function automatic t_res predict_update(t_item it);
        t_res r;
        int hit;
        int spare;
        int removed;
        r = '0;
        hit = -1;
        spare = -1;
        removed = 0;
        if (it.op) begin
            for (int i = 0; i < scdt_pkg::Sessions; i++) begin
                if (tv[i] && it.now > tseen[i] && (it.now - tseen[i]) > idle_limit) begin
                    tv[i] = 1'b0;
                    tflag[i] = 1'b0;
                    removed++;
                end
            end
            r.status = scdt_pkg::ST_SWEEP;
            r.rem = (removed > 31) ? 5'd31 : removed[4:0];
            return r;
        end
        for (int i = 0; i < scdt_pkg::Sessions; i++) begin
            if (tv[i]) begin
                if (hit < 0 && tkey[i] == it.sid) hit = i;
            end else if (spare < 0) begin
                spare = i;
            end
        end
        if (hit < 0) begin
            if (spare < 0) begin
                r.status = scdt_pkg::ST_FULL;
                return r;
            end
            tv[spare] = 1'b1;
            tflag[spare] = 1'b0;
            tkey[spare] = it.sid;
            hit = spare;
            r.status = scdt_pkg::ST_NEW;
        end else if (tflag[hit]) begin
            tflag[hit] = 1'b0;
            r.status = scdt_pkg::ST_NEW;
        end else if (it.c0 < tb0[hit] || it.c1 < tb1[hit] ||
                     it.c2 < tb2[hit] || it.c3 < tb3[hit]) begin
            tflag[hit] = 1'b1;
            r.status = scdt_pkg::ST_SHRINK;
        end else begin
            r.status = scdt_pkg::ST_DELTA;
            r.d0 = it.c0 - tb0[hit];
            r.d1 = it.c1 - tb1[hit];
            r.d2 = it.c2 - tb2[hit];
            r.d3 = it.c3 - tb3[hit];
            r.el = (it.now > tseen[hit]) ? it.now - tseen[hit] : 48'd1;
        end
        tb0[hit] = it.c0;
        tb1[hit] = it.c1;
        tb2[hit] = it.c2;
        tb3[hit] = it.c3;
        tseen[hit] = it.now;
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("[session_counter_delta_table] ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        in_fire <= i_rst_n && in_ch.valid && in_ch.ready;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_fire) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                t_item it;
                it = pending_items.pop_front();
                expected_results.push_back(predict_update(it));
                in_ch.valid <= 1'b1;
                in_ch.op <= it.op;
                in_ch.session_id <= it.sid;
                in_ch.in_tokens <= it.c0;
                in_ch.out_tokens <= it.c1;
                in_ch.cache_make_tokens <= it.c2;
                in_ch.cache_hit_tokens <= it.c3;
                in_ch.now_ms <= it.now;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
        out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            t_res got;
            t_res exp_r;
            got = {out_ch.status, out_ch.delta_in, out_ch.delta_out,
                   out_ch.delta_cache_make, out_ch.delta_cache_hit,
                   out_ch.elapsed_ms, out_ch.removed_count};
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t unexpected transaction: %p", $time, got);
            end else begin
                exp_r = expected_results.pop_front();
                if (got !== exp_r) begin
                    errors++;
                    $display("%0t mismatch: expected %p actual %p", $time, exp_r, got);
                end
            end
        end
    end

    task automatic write_limit(input logic [47:0] v);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= v;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        idle_limit = v;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic drain_all();
        int guard;
        guard = 0;
        while ((pending_items.size() > 0 || expected_results.size() > 0 || in_ch.valid)
               && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (10) @(posedge i_clk);
    endtask

    function automatic logic [47:0] rnd48();
        return 48'({$urandom(), $urandom()});
    endfunction

    function automatic t_item mk(logic op, logic [31:0] sid, logic [47:0] c0,
                                 logic [47:0] c1, logic [47:0] c2, logic [47:0] c3,
                                 logic [47:0] now);
        t_item it;
        it = {op, sid, c0, c1, c2, c3, now};
        return it;
    endfunction

    logic [47:0] sim_now;
    logic [47:0] keyc[8][4];
    logic [31:0] keys[8];

    task automatic gen_random(input int n);
        int k;
        int sel;
        logic [47:0] c[4];
        for (int j = 0; j < n; j++) begin
            sel = $urandom_range(99);
            sim_now = sim_now + $urandom_range(3000) - 200;
            if ($urandom_range(19) == 0) sim_now = rnd48();
            if (sel < 6) begin
                pending_items.push_back(mk(1'b1, $urandom(), rnd48(), rnd48(), rnd48(),
                                           rnd48(), sim_now));
            end else if (sel < 12) begin
                pending_items.push_back(mk(1'b0, $urandom(), rnd48(), rnd48(), rnd48(),
                                           rnd48(), rnd48()));
            end else begin
                k = $urandom_range(7);
                for (int m = 0; m < 4; m++) begin
                    if ($urandom_range(24) == 0) keyc[k][m] = rnd48();
                    else keyc[k][m] = keyc[k][m] + $urandom_range(5000);
                    c[m] = keyc[k][m];
                end
                pending_items.push_back(mk(1'b0, keys[k], c[0], c[1], c[2], c[3], sim_now));
            end
        end
    endtask

    initial begin
        errors = 0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        idle_limit = scdt_pkg::IdleReset;
        for (int i = 0; i < scdt_pkg::Sessions; i++) begin
            tv[i] = 1'b0;
            tflag[i] = 1'b0;
        end
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.op = 1'b0;
        in_ch.session_id = '0;
        in_ch.in_tokens = '0;
        in_ch.out_tokens = '0;
        in_ch.cache_make_tokens = '0;
        in_ch.cache_hit_tokens = '0;
        in_ch.now_ms = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        pending_items.push_back(mk(1'b0, 32'hFFFF_FFFF, '1, '1, '1, '1, 48'd100));
        pending_items.push_back(mk(1'b0, 32'hFFFF_FFFF, '1, '1, '1, '1, 48'd100));
        pending_items.push_back(mk(1'b0, 32'h0, '0, '0, '0, '0, 48'd50));
        pending_items.push_back(mk(1'b0, 32'h0, 48'd10, 48'd20, 48'd30, 48'd40, 48'd40));
        pending_items.push_back(mk(1'b0, 32'h0, 48'd9, 48'd20, 48'd30, 48'd40, 48'd60));
        pending_items.push_back(mk(1'b0, 32'h0, 48'd1, 48'd2, 48'd3, 48'd4, 48'd70));
        pending_items.push_back(mk(1'b0, 32'h0, '1, '1, '1, '1, '1));
        pending_items.push_back(mk(1'b0, 32'hFFFF_FFFF, '1, '1, '1, 48'd5, 48'd200));
        for (int i = 2; i < 18; i++)
            pending_items.push_back(mk(1'b0, i * 32'h1111_0001, rnd48(), rnd48(), rnd48(),
                                       rnd48(), 48'd1000));
        pending_items.push_back(mk(1'b1, 32'h0, '0, '0, '0, '0, 48'd61000));
        pending_items.push_back(mk(1'b1, 32'h0, '0, '0, '0, '0, 48'd61001));
        pending_items.push_back(mk(1'b1, 32'hFFFF_FFFF, '1, '1, '1, '1, '1));
        drain_all();

        for (int k = 0; k < 8; k++) begin
            keys[k] = $urandom();
            for (int m = 0; m < 4; m++) keyc[k][m] = rnd48() >> 2;
        end
        sim_now = 48'd1000;

        write_limit(48'd0);
        src_idle_pct = 0; snk_stall_pct = 0;
        gen_random(275);
        drain_all();
        write_limit(48'd2000);
        src_idle_pct = 57; snk_stall_pct = 0;
        gen_random(275);
        drain_all();
        write_limit(48'hFFFF_FFFF_FFFF);
        src_idle_pct = 0; snk_stall_pct = 57;
        gen_random(275);
        drain_all();
        write_limit(48'($urandom_range(32'hFFFF)));
        src_idle_pct = 38; snk_stall_pct = 38;
        gen_random(275);
        drain_all();

        if (errors == 0 && expected_results.size() == 0) begin
            $display("[session_counter_delta_table] OK");
        end else begin
            $display("[session_counter_delta_table] ERROR");
        end
        $finish;
    end
endmodule

[files.f]
sv/scdt_pkg.sv
sv/scdt_if.sv
sv/scdt_datapath.sv
sv/scdt_ctrl.sv
sv/session_counter_delta_table.sv
tb/tb_session_counter_delta_table.sv
